/* rtl/fcbb_pkg.sv */
package fcbb_pkg;

    localparam int SIZE_W = 24;
    localparam int CNT_W = 6;
    localparam int KEY_IN_W = 64;
    localparam logic [SIZE_W-1:0] BUDGET_RESET = 24'd6291456;

    localparam logic OP_STORE = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_DROP,
        ST_EVICT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic compare;
        logic drop_hit;
        logic evict;
        logic append;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic is_store;
        logic hit;
        logic need_evict;
    } sts_t;

endpackage

/* rtl/fifo_cache_byte_budget_unit.sv */
// Flow: a word is captured, compared against the row, and its result loaded; a store also
// drops the entry with its key if present, evicts oldest entries while over budget or full,
// then appends. One word in flight; the next word is accepted only after the result loads,
// and a held result delays it.
// Reset (aresetn low, synchronous): row empty, byte total zero, budget 6291456,
// no result pending.
module fifo_cache_byte_budget_unit #(
    parameter int MAX_ENTRIES = 48,
    parameter int KEY_BITS = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fcbb_pkg::SIZE_W-1:0]     cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_opcode,
    input  logic [fcbb_pkg::KEY_IN_W-1:0]   s_key,
    input  logic [fcbb_pkg::SIZE_W-1:0]     s_size,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_found,
    output logic [fcbb_pkg::CNT_W-1:0]      m_evicted,
    output logic [fcbb_pkg::SIZE_W-1:0]     m_bytes_used,
    output logic [fcbb_pkg::CNT_W-1:0]      m_entries_used
);
    import fcbb_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    fcbb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    fcbb_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .KEY_BITS    (KEY_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_data       (cfg_data),
        .s_opcode       (s_opcode),
        .s_key          (s_key),
        .s_size         (s_size),
        .cmd            (cmd),
        .sts            (sts),
        .m_found        (m_found),
        .m_evicted      (m_evicted),
        .m_bytes_used   (m_bytes_used),
        .m_entries_used (m_entries_used)
    );

endmodule

/* rtl/fcbb_ctrl.sv */
module fcbb_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  fcbb_pkg::sts_t sts,
    output fcbb_pkg::cmd_t cmd
);
    import fcbb_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_valid) state_next = ST_CMP;
            ST_CMP: begin
                if (!sts.is_store) state_next = ST_DONE;
                else if (sts.hit) state_next = ST_DROP;
                else state_next = ST_EVICT;
            end
            ST_DROP:  state_next = ST_EVICT;
            ST_EVICT: if (!sts.need_evict) state_next = ST_DONE;
            ST_DONE:  if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE:  cmd.capture = s_valid;
            ST_CMP:   cmd.compare = 1'b1;
            ST_DROP:  cmd.drop_hit = 1'b1;
            ST_EVICT: begin
                cmd.evict  = sts.need_evict;
                cmd.append = !sts.need_evict;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

/* rtl/fcbb_dp.sv */
module fcbb_dp #(
    parameter int MAX_ENTRIES = 48,
    parameter int KEY_BITS = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    input  logic [fcbb_pkg::SIZE_W-1:0]     cfg_data,
    input  logic                            s_opcode,
    input  logic [fcbb_pkg::KEY_IN_W-1:0]   s_key,
    input  logic [fcbb_pkg::SIZE_W-1:0]     s_size,
    input  fcbb_pkg::cmd_t                  cmd,
    output fcbb_pkg::sts_t                  sts,
    output logic                            m_found,
    output logic [fcbb_pkg::CNT_W-1:0]      m_evicted,
    output logic [fcbb_pkg::SIZE_W-1:0]     m_bytes_used,
    output logic [fcbb_pkg::CNT_W-1:0]      m_entries_used
);
    import fcbb_pkg::*;

    localparam int CW = $clog2(MAX_ENTRIES + 1);

    logic [KEY_BITS-1:0]    key_row_reg  [MAX_ENTRIES];
    logic [SIZE_W-1:0]      size_row_reg [MAX_ENTRIES];
    logic [CW-1:0]          count_reg;
    logic [SIZE_W-1:0]      total_reg;
    logic [SIZE_W-1:0]      budget_reg;
    logic                   op_reg;
    logic [KEY_BITS-1:0]    key_reg;
    logic [SIZE_W-1:0]      sz_reg;
    logic                   hit_reg;
    logic [MAX_ENTRIES-1:0] ge_reg;
    logic [SIZE_W-1:0]      hit_size_reg;
    logic [CNT_W-1:0]       evc_reg;

    logic [MAX_ENTRIES-1:0] match, first;
    logic [SIZE_W-1:0]      hit_size;
    logic [SIZE_W:0]        sum;
    logic                   shift_en;
    logic [MAX_ENTRIES-1:0] shift_mask;

    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            match[i] = (key_row_reg[i] == key_reg) && (CW'(i) < count_reg);
        end
        first = match & ~(match - MAX_ENTRIES'(1));
        hit_size = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            hit_size = hit_size | (first[i] ? size_row_reg[i] : '0);
        end
    end

    assign sum = {1'b0, total_reg} + {1'b0, sz_reg};
    assign sts.is_store = (op_reg == OP_STORE);
    assign sts.hit = |match;
    assign sts.need_evict = (count_reg != '0) &&
        ((sum > {1'b0, budget_reg}) || (count_reg == CW'(MAX_ENTRIES)));

    assign shift_en = cmd.drop_hit || cmd.evict;
    assign shift_mask = cmd.evict ? '1 : ge_reg;

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (shift_en && shift_mask[i] && (i + 1 < MAX_ENTRIES)) begin
                key_row_reg[i]  <= key_row_reg[(i + 1) % MAX_ENTRIES];
                size_row_reg[i] <= size_row_reg[(i + 1) % MAX_ENTRIES];
            end else if (cmd.append && (CW'(i) == count_reg)) begin
                key_row_reg[i]  <= key_reg;
                size_row_reg[i] <= sz_reg;
            end
        end
        if (cmd.capture) begin
            op_reg  <= s_opcode;
            key_reg <= s_key[KEY_BITS-1:0];
            sz_reg  <= s_size;
        end
        if (cmd.compare) begin
            hit_reg      <= |match;
            ge_reg       <= ~(first - MAX_ENTRIES'(1));
            hit_size_reg <= hit_size;
        end
        if (cmd.load_out) begin
            m_found        <= hit_reg;
            m_evicted      <= evc_reg;
            m_bytes_used   <= total_reg;
            m_entries_used <= CNT_W'(count_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            total_reg  <= '0;
            budget_reg <= BUDGET_RESET;
            evc_reg    <= '0;
        end else begin
            if (cfg_valid) budget_reg <= cfg_data;
            if (cmd.capture) evc_reg <= '0;
            if (cmd.drop_hit) begin
                count_reg <= count_reg - CW'(1);
                total_reg <= total_reg - hit_size_reg;
            end else if (cmd.evict) begin
                count_reg <= count_reg - CW'(1);
                total_reg <= total_reg - size_row_reg[0];
                evc_reg   <= evc_reg + CNT_W'(1);
            end else if (cmd.append) begin
                count_reg <= count_reg + CW'(1);
                total_reg <= sum[SIZE_W-1:0];
            end
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_ENTRIES)) else $error("entry count overflow");
    a_append_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.append |-> count_reg != CW'(MAX_ENTRIES)) else $error("append on full row");
    a_evict_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.evict |-> count_reg != '0) else $error("evict on empty row");
    a_drop_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.drop_hit |-> hit_reg) else $error("drop without hit");

endmodule

/* tb/fifo_cache_byte_budget_unit_test.sv */
module fifo_cache_byte_budget_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import fcbb_pkg::*;

    localparam int DEPTH = 48;
    localparam int LIMIT_CYCLES = 1000000;

    typedef struct packed {
        logic              opcode;
        logic [63:0]       key;
        logic [SIZE_W-1:0] size;
    } req_t;

    typedef struct packed {
        logic             found;
        logic [CNT_W-1:0] evicted;
        logic [SIZE_W-1:0] bytes_used;
        logic [CNT_W-1:0] entries_used;
    } rsp_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [SIZE_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_opcode = 1'b0;
    logic [63:0] s_key = '0;
    logic [SIZE_W-1:0] s_size = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_found;
    logic [CNT_W-1:0] m_evicted;
    logic [SIZE_W-1:0] m_bytes_used;
    logic [CNT_W-1:0] m_entries_used;

    fifo_cache_byte_budget_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode),
        .s_key(s_key), .s_size(s_size),
        .m_valid(m_valid), .m_ready(m_ready), .m_found(m_found),
        .m_evicted(m_evicted), .m_bytes_used(m_bytes_used),
        .m_entries_used(m_entries_used)
    );

    always #4 aclk = ~aclk;

    // directory model
    logic [63:0]       dir_keys[DEPTH];
    logic [SIZE_W-1:0] dir_sizes[DEPTH];
    int                dir_count = 0;
    logic [SIZE_W-1:0] dir_total = '0;
    logic [SIZE_W-1:0] budget = BUDGET_RESET;

    req_t pending_words[$];
    rsp_t expected_rsps[$];
    int   mismatches = 0;
    int   cycles = 0;
    bit   stim_done = 1'b0;
    bit   hold_off = 1'b0;
    bit   cfg_req = 1'b0;
    logic [SIZE_W-1:0] cfg_word = '0;

    function automatic void dir_drop(input int pos);
        dir_total = dir_total - dir_sizes[pos];
        for (int i = pos; i + 1 < dir_count; i++) begin
            dir_keys[i] = dir_keys[i+1];
            dir_sizes[i] = dir_sizes[i+1];
        end
        dir_count--;
    endfunction

    function automatic rsp_t apply_word(input req_t w);
        rsp_t r;
        int pos;
        int ev;
        pos = -1;
        ev = 0;
        for (int i = 0; i < dir_count; i++)
            if (pos < 0 && dir_keys[i] == w.key) pos = i;
        if (w.opcode == OP_STORE) begin
            if (pos >= 0) dir_drop(pos);
            while (dir_count > 0 &&
                   ({1'b0, dir_total} + {1'b0, w.size} > {1'b0, budget} ||
                    dir_count >= DEPTH)) begin
                dir_drop(0);
                ev++;
            end
            dir_keys[dir_count] = w.key;
            dir_sizes[dir_count] = w.size;
            dir_count++;
            dir_total = dir_total + w.size;
        end
        r.found = (pos >= 0);
        r.evicted = ev[CNT_W-1:0];
        r.bytes_used = dir_total;
        r.entries_used = dir_count[CNT_W-1:0];
        return r;
    endfunction

    function automatic void add_word(input req_t w);
        pending_words.insert(pending_words.size(), w);
    endfunction

    // driver
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) cfg_valid <= 1'b0;
            else if (cfg_req && !cfg_valid) begin
                cfg_valid <= 1'b1;
                cfg_data <= cfg_word;
            end
            if (s_valid && s_ready) begin
                expected_rsps.insert(expected_rsps.size(), apply_word(pending_words[0]));
                pending_words.delete(0);
            end
            if (!(s_valid && !s_ready)) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid <= 1'b0;
                end else if (pending_words.size() > 0 && !hold_off) begin
                    s_valid <= 1'b1;
                    s_opcode <= pending_words[0].opcode;
                    s_key <= pending_words[0].key;
                    s_size <= pending_words[0].size;
                    if (burst_left > 0) burst_left <= burst_left - 1;
                    else begin
                        burst_left <= $urandom_range(0, 20);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else s_valid <= 1'b0;
            end
        end
    end

    // monitor
    int stall_phase = 0;
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn) begin
            stall_phase <= (stall_phase + 1) % 37;
            m_ready <= (stall_phase < 12) ? 1'b1 : ($urandom_range(0, 2) != 0);
            if (m_valid && m_ready) begin
                if (expected_rsps.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result word");
                end else begin
                    rsp_t e;
                    e = expected_rsps[0];
                    expected_rsps.delete(0);
                    if (e.found !== m_found || e.evicted !== m_evicted ||
                        e.bytes_used !== m_bytes_used ||
                        e.entries_used !== m_entries_used) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp f=%0d ev=%0d b=%0d n=%0d got f=%0d ev=%0d b=%0d n=%0d",
                                     e.found, e.evicted, e.bytes_used, e.entries_used,
                                     m_found, m_evicted, m_bytes_used, m_entries_used);
                    end
                end
            end
        end
        if (cycles > LIMIT_CYCLES) begin
            $display("fifo_cache_byte_budget_unit_test failed");
            $finish;
        end
    end

    function automatic req_t mk(input logic op, input logic [63:0] k, input int sz);
        req_t w;
        w.opcode = op;
        w.key = k;
        w.size = sz[SIZE_W-1:0];
        return w;
    endfunction

    task automatic wait_drained();
        while (pending_words.size() > 0 || s_valid || expected_rsps.size() > 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_budget(input logic [SIZE_W-1:0] v);
        cfg_word = v;
        cfg_req = 1'b1;
        @(posedge aclk);
        while (!(cfg_valid && cfg_ready)) @(posedge aclk);
        cfg_req = 1'b0;
        budget = v;
        @(posedge aclk);
    endtask

    task automatic random_phase(input int n, input int key_span, input int max_sz);
        for (int i = 0; i < n; i++) begin
            logic [63:0] k;
            int sz;
            if ($urandom_range(0, 9) == 0) k = {$urandom, $urandom};
            else k = 64'($urandom_range(0, key_span));
            sz = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 24'hFFFFFF)
                                              : $urandom_range(0, max_sz);
            add_word(mk($urandom_range(0, 2) == 0, k, sz));
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // directed
        add_word(mk(OP_LOOKUP, 64'd0, 0));
        add_word(mk(OP_STORE, 64'd0, 0));
        add_word(mk(OP_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 24'hFFFFFF));
        add_word(mk(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 0));
        add_word(mk(OP_STORE, 64'h5555_AAAA_5555_AAAA, 1000));
        add_word(mk(OP_STORE, 64'hAAAA_5555_AAAA_5555, 3000000));
        add_word(mk(OP_STORE, 64'h5555_AAAA_5555_AAAA, 3291456));
        add_word(mk(OP_STORE, 64'd7, 1));
        add_word(mk(OP_LOOKUP, 64'hAAAA_5555_AAAA_5555, 24'hFFFFFF));
        for (int i = 0; i < 50; i++) add_word(mk(OP_STORE, 64'(100 + i), 5));
        add_word(mk(OP_LOOKUP, 64'd101, 0));
        add_word(mk(OP_LOOKUP, 64'd102, 0));
        wait_drained();
        write_budget(24'd20);
        add_word(mk(OP_STORE, 64'd1, 3));
        add_word(mk(OP_LOOKUP, 64'd149, 0));
        wait_drained();
        write_budget(24'd0);
        random_phase(300, 60, 4);
        while (pending_words.size() > 150) @(posedge aclk);
        hold_off = 1'b1;
        while (s_valid || expected_rsps.size() > 0) @(posedge aclk);
        hold_off = 1'b0;
        wait_drained();
        write_budget(24'd100);
        random_phase(500, 80, 30);
        wait_drained();
        write_budget(24'hFFFFFF);
        random_phase(500, 120, 300000);
        wait_drained();
        write_budget(24'd5000);
        random_phase(600, 70, 400);
        wait_drained();
        if (mismatches == 0) $display("fifo_cache_byte_budget_unit_test passed");
        else $display("fifo_cache_byte_budget_unit_test failed");
        $finish;
    end
endmodule
